// ===== hw/rtl/srle_pkg.sv =====
// ----------------------------------------------------------------------------
// srle_pkg
// Shared constants and types of the sprite row skip/literal encoder.
// ----------------------------------------------------------------------------
package srle_pkg;

   localparam int MAX_WIDTH   = 60;
   localparam int MAX_RESULTS = 64;
   localparam int IDX_W       = $clog2(MAX_WIDTH);
   localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
   localparam int SKIP_W      = 6;
   localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] TRANSPARENT  = 8'hFF;
   localparam logic [7:0] CODE_SKIP    = 8'd0;
   localparam logic [7:0] CODE_LITERAL = 8'd3;

   localparam logic [SKIP_W-1:0] SKIP_SAT = '1;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_SKIP = 2'd1;
   localparam logic [1:0] MODE_LIT  = 2'd2;

   // One byte handed from the sequencer to the output register.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       item_done;
      logic       row_done;
   } emit_type;

   // What one accepted item has to write, in stream order.
   typedef struct packed {
      logic              pre;       // owed terminator of the previous row
      logic              skiphdr;   // skip code and run length
      logic              flush;     // literal packet
      logic              endskip;   // skip run closing the row
      logic              post;      // row terminator
      logic [SKIP_W-1:0] skip_len;
      logic [CNT_W-1:0]  lit_cnt;
   } plan_type;

endpackage

// ===== hw/rtl/srle_store.sv =====
// ----------------------------------------------------------------------------
// srle_store
// Literal pixel buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srle_store
   import srle_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [0:MAX_WIDTH-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/srle_ctrl.sv =====
// ----------------------------------------------------------------------------
// srle_ctrl
// Run tracking and byte sequencer: plans an item's packets when accepted,
// buffers literal pixels, then emits the bytes one per cycle unless stalled.
// ----------------------------------------------------------------------------
module srle_ctrl
   import srle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_pixel,
   input  logic             req_row_end,
   output logic             emit_valid,
   input  logic             emit_ready,
   output emit_type         emit,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output logic [7:0]       mem_wr_data,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  logic [7:0]       mem_rd_data
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_PRE0     = 4'd1;
   localparam logic [3:0] PH_PRE1     = 4'd2;
   localparam logic [3:0] PH_SKIP0    = 4'd3;
   localparam logic [3:0] PH_SKIP1    = 4'd4;
   localparam logic [3:0] PH_LIT_CODE = 4'd5;
   localparam logic [3:0] PH_LIT_CNT  = 4'd6;
   localparam logic [3:0] PH_LIT_DATA = 4'd7;
   localparam logic [3:0] PH_END0     = 4'd8;
   localparam logic [3:0] PH_END1     = 4'd9;
   localparam logic [3:0] PH_POST0    = 4'd10;
   localparam logic [3:0] PH_POST1    = 4'd11;

   localparam logic [2:0] GRP_PRE  = 3'd0;
   localparam logic [2:0] GRP_SKIP = 3'd1;
   localparam logic [2:0] GRP_LIT  = 3'd2;
   localparam logic [2:0] GRP_END  = 3'd3;
   localparam logic [2:0] GRP_POST = 3'd4;

   // First packet of the plan at or after the given group.
   function automatic logic [3:0] first_from(input logic [2:0] g, input plan_type p);
      logic [3:0] ph;
      ph = PH_IDLE;
      if (g <= GRP_POST && p.post)         ph = PH_POST0;
      if (g <= GRP_END  && p.endskip)      ph = PH_END0;
      if (g <= GRP_LIT  && p.flush)        ph = PH_LIT_CODE;
      if (g <= GRP_SKIP && p.skiphdr)      ph = PH_SKIP0;
      if (g == GRP_PRE  && p.pre)          ph = PH_PRE0;
      return ph;
   endfunction

   logic [3:0]        phase_ff, phase_in, phase_next;
   plan_type          plan_ff, plan_in, plan_new;
   logic [1:0]        mode_ff, mode_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic [CNT_W-1:0]  lc_ff, lc_in;
   logic              owed_ff, owed_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              accept;
   logic              advance;
   logic              last_data;
   logic [CNT_W-1:0]  lc_inc;
   logic [NCNT_W-1:0] n_total;

   assign req_ready = (phase_ff == PH_IDLE);
   assign accept    = req_valid && req_ready;
   assign advance   = emit_valid && emit_ready;
   assign last_data = ({1'b0, idx_ff} + 7'd1) == {1'b0, plan_ff.lit_cnt};

   // Plan and run state update for the item being offered.
   always_comb begin
      plan_new          = '0;
      plan_new.pre      = owed_ff;
      mode_in           = mode_ff;
      skip_in           = skip_ff;
      lc_in             = lc_ff;
      owed_in           = owed_ff;
      lc_inc            = (lc_ff < CNT_W'(MAX_WIDTH)) ? lc_ff + 1'b1 : lc_ff;
      n_total           = '0;
      mem_wr_en         = 1'b0;
      if (req_pixel == TRANSPARENT) begin
         plan_new.flush   = (mode_ff == MODE_LIT) && (lc_ff != '0);
         plan_new.lit_cnt = lc_ff;
         lc_in            = '0;
         if (mode_ff == MODE_SKIP) begin
            skip_in = (skip_ff == SKIP_SAT) ? skip_ff : skip_ff + 1'b1;
         end else begin
            skip_in = SKIP_W'(1);
         end
         mode_in = MODE_SKIP;
         owed_in = 1'b0;
         if (req_row_end) begin
            plan_new.endskip = 1'b1;
            n_total = (owed_ff ? NCNT_W'(2) : '0)
                    + (plan_new.flush ? NCNT_W'(2) + NCNT_W'(lc_ff) : '0)
                    + NCNT_W'(2);
            // A row whose bytes would not fit in one item defers its terminator.
            plan_new.post = (n_total <= NCNT_W'(MAX_RESULTS - 2));
            owed_in       = !plan_new.post;
            mode_in       = MODE_IDLE;
            skip_in       = '0;
         end
      end else begin
         plan_new.skiphdr  = (mode_ff == MODE_SKIP);
         plan_new.skip_len = skip_ff;
         skip_in           = '0;
         mem_wr_en         = accept && (lc_ff < CNT_W'(MAX_WIDTH));
         owed_in           = 1'b0;
         mode_in           = MODE_LIT;
         lc_in             = lc_inc;
         if (req_row_end || lc_inc >= CNT_W'(MAX_WIDTH)) begin
            plan_new.flush   = 1'b1;
            plan_new.lit_cnt = lc_inc;
            plan_new.post    = req_row_end;
            mode_in          = MODE_IDLE;
            lc_in            = '0;
         end
      end
   end

   assign mem_wr_addr = lc_ff[IDX_W-1:0];
   assign mem_wr_data = req_pixel;

   // Phase that follows the current byte.
   always_comb begin
      case (phase_ff)
         PH_PRE0:     phase_next = PH_PRE1;
         PH_PRE1:     phase_next = first_from(GRP_SKIP, plan_ff);
         PH_SKIP0:    phase_next = PH_SKIP1;
         PH_SKIP1:    phase_next = first_from(GRP_LIT, plan_ff);
         PH_LIT_CODE: phase_next = PH_LIT_CNT;
         PH_LIT_CNT:  phase_next = PH_LIT_DATA;
         PH_LIT_DATA: phase_next = last_data ? first_from(GRP_END, plan_ff) : PH_LIT_DATA;
         PH_END0:     phase_next = PH_END1;
         PH_END1:     phase_next = first_from(GRP_POST, plan_ff);
         PH_POST0:    phase_next = PH_POST1;
         PH_POST1:    phase_next = PH_IDLE;
         default:     phase_next = PH_IDLE;
      endcase
   end

   always_comb begin
      emit_valid     = (phase_ff != PH_IDLE);
      emit.item_done = (phase_next == PH_IDLE);
      emit.row_done  = (phase_ff == PH_PRE1) || (phase_ff == PH_POST1);
      case (phase_ff)
         PH_SKIP1:    emit.out_byte = {{(8-SKIP_W){1'b0}}, plan_ff.skip_len};
         PH_LIT_CODE: emit.out_byte = CODE_LITERAL;
         PH_LIT_CNT:  emit.out_byte = {{(8-CNT_W){1'b0}}, plan_ff.lit_cnt};
         PH_LIT_DATA: emit.out_byte = mem_rd_data;
         default:     emit.out_byte = CODE_SKIP;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      plan_in  = plan_ff;
      idx_in   = idx_ff;
      if (accept) begin
         phase_in = first_from(GRP_PRE, plan_new);
         plan_in  = plan_new;
         idx_in   = '0;
      end else if (advance) begin
         phase_in = phase_next;
         if (phase_ff == PH_LIT_DATA) begin
            idx_in = last_data ? '0 : idx_ff + 1'b1;
         end
      end
   end

   // The read address is the next value of the index, so that the registered data
   // always belongs to the pixel being emitted.
   assign mem_rd_addr = idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         plan_ff  <= '0;
         mode_ff  <= MODE_IDLE;
         skip_ff  <= '0;
         lc_ff    <= '0;
         owed_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         plan_ff  <= plan_in;
         idx_ff   <= idx_in;
         if (accept) begin
            mode_ff <= mode_in;
            skip_ff <= skip_in;
            lc_ff   <= lc_in;
            owed_ff <= owed_in;
         end
      end
   end

endmodule

// ===== hw/rtl/sprite_row_skip_literal_encoder.sv =====
// The first byte of an item passes the phase register and then the output
// register before it shows on rsp_. An item's bytes come one per cycle while
// rsp_ready is high; the input stays held until all reach the output register.
// Literal bytes are read from the pixel buffer, whose read data is registered.
// Reset clears the run state, the sequencer and the valid flag of the output
// register; the pixel buffer is not cleared, and only written bytes are emitted.
// ----------------------------------------------------------------------------
// sprite_row_skip_literal_encoder
// Encodes sprite rows into skip and literal packets with row terminators.
// ----------------------------------------------------------------------------
module sprite_row_skip_literal_encoder
   import srle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel,
   input  logic       req_row_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_item_done,
   output logic       rsp_row_done
);

   logic             emit_valid;
   logic             emit_ready;
   emit_type         emit;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [7:0]       mem_rd_data;
   logic             rsp_valid_ff, rsp_valid_in;
   emit_type         rsp_ff;

   srle_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel   (req_pixel),
      .req_row_end (req_row_end),
      .emit_valid  (emit_valid),
      .emit_ready  (emit_ready),
      .emit        (emit),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   srle_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: takes a new byte whenever it is empty or being drained.
   assign emit_ready   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = emit_valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_valid && emit_ready) begin
         rsp_ff <= emit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_ff.out_byte;
   assign rsp_item_done = rsp_ff.item_done;
   assign rsp_row_done  = rsp_ff.row_done;

endmodule

// ===== hw/rtl/srle_checker.sv =====
// ----------------------------------------------------------------------------
// srle_checker
// Port-level checks of the sprite row encoder, bound to the top level.
// ----------------------------------------------------------------------------
module srle_checker
   import srle_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_pixel,
   input logic       req_row_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_item_done,
   input logic       rsp_row_done
);

   // A stalled result item keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_item_done) && $stable(rsp_row_done))
      else $error("result item changed while stalled");

   // The closing byte of a row terminator is always zero.
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_done |-> rsp_out_byte == CODE_SKIP)
      else $error("row terminator byte is not zero");

   // A pixel that ends a row always produces bytes, so the input stalls next.
   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_row_end |=> !req_ready)
      else $error("row end item accepted without output");

   // Nothing is offered right after a reset cycle.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An offered input item stays offered and unchanged until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_pixel)
         && $stable(req_row_end))
      else $error("input item changed while waiting");

endmodule

bind sprite_row_skip_literal_encoder srle_checker u_srle_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_pixel     (req_pixel),
   .req_row_end   (req_row_end),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_item_done (rsp_item_done),
   .rsp_row_done  (rsp_row_done)
);

// ===== bench/sprite_row_skip_literal_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_row_skip_literal_encoder_test
// Drives pixel rows into the encoder with random idling on both channels and
// checks every output byte against a local model of the skip/literal coding.
// ----------------------------------------------------------------------------
module sprite_row_skip_literal_encoder_test;
   import srle_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD    = 300;

   // Bytes of the stream that are not packet codes.
   localparam logic [7:0] TERM_BYTE   = 8'd0;
   localparam logic [7:0] END_RUN_LEN = 8'd0;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_pixel   = 8'd0;
   logic       req_row_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_item_done;
   logic       rsp_row_done;

   // Model of the encoder state.
   logic [1:0]        run_mode   = MODE_IDLE;
   logic [SKIP_W-1:0] skip_len   = '0;
   logic [7:0]        lit_buf [MAX_WIDTH];
   logic [CNT_W-1:0]  lit_count  = '0;
   bit                owe_term   = 1'b0;

   emit_type encoded_stream [$];

   bit idling_on   = 1'b1;
   int hold_asks   = 0;
   int holds_done  = 0;
   int hold_left   = 0;
   int stall_left  = 0;
   int fail_count  = 0;
   int cycle_count = 0;
   int pixels_seen = 0;
   int rows_seen   = 0;
   int bytes_seen  = 0;

   sprite_row_skip_literal_encoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .req_row_end   (req_row_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_item_done (rsp_item_done),
      .rsp_row_done  (rsp_row_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Expected stream
   // ------------------------------------------------------------------------
   task automatic put_byte(input logic [7:0] b, input logic last_of_row, inout int n);
      emit_type e;
      e.out_byte  = b;
      e.item_done = 1'b0;
      e.row_done  = last_of_row;
      encoded_stream.push_back(e);
      n++;
   endtask

   task automatic put_row_end(inout int n);
      put_byte(TERM_BYTE, 1'b0, n);
      put_byte(TERM_BYTE, 1'b1, n);
   endtask

   task automatic put_literal_packet(inout int n);
      put_byte(CODE_LITERAL, 1'b0, n);
      put_byte(8'(lit_count), 1'b0, n);
      for (int i = 0; i < lit_count; i++)
         put_byte(lit_buf[i], 1'b0, n);
      lit_count = '0;
   endtask

   task automatic encode_pixel(input logic [7:0] px, input logic row_end);
      int n;
      n = 0;
      if (owe_term) begin
         put_row_end(n);
         owe_term = 1'b0;
      end
      if (px == TRANSPARENT) begin
         if (run_mode == MODE_LIT && lit_count > 0)
            put_literal_packet(n);
         lit_count = '0;
         if (run_mode == MODE_SKIP) begin
            if (skip_len != SKIP_SAT)
               skip_len++;
         end else begin
            skip_len = SKIP_W'(1);
         end
         run_mode = MODE_SKIP;
         if (row_end) begin
            put_byte(CODE_SKIP, 1'b0, n);
            put_byte(END_RUN_LEN, 1'b0, n);
            // A terminator that would not fit is written by the next item.
            if (n + 2 > MAX_RESULTS)
               owe_term = 1'b1;
            else
               put_row_end(n);
            run_mode = MODE_IDLE;
            skip_len = '0;
         end
      end else begin
         if (run_mode == MODE_SKIP) begin
            put_byte(CODE_SKIP, 1'b0, n);
            put_byte(8'(skip_len), 1'b0, n);
            skip_len = '0;
         end
         if (lit_count < MAX_WIDTH) begin
            lit_buf[lit_count] = px;
            lit_count++;
         end
         run_mode = MODE_LIT;
         if (row_end || lit_count >= MAX_WIDTH) begin
            put_literal_packet(n);
            run_mode = MODE_IDLE;
            if (row_end)
               put_row_end(n);
         end
      end
      if (n > 0)
         encoded_stream[encoded_stream.size() - 1].item_done = 1'b1;
   endtask

   // Both channels are sampled here, before any update of this edge lands.
   always @(posedge clock) begin : stream_check
      emit_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (encoded_stream.size() == 0) begin
               $error("unexpected byte: out_byte %0h", rsp_out_byte);
               fail_count++;
            end else begin
               want = encoded_stream.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_item_done !== want.item_done) begin
                  $error("item_done: expected %0b, got %0b", want.item_done, rsp_item_done);
                  fail_count++;
               end
               if (rsp_row_done !== want.row_done) begin
                  $error("row_done: expected %0b, got %0b", want.row_done, rsp_row_done);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_pixel(req_pixel, req_row_end);
            pixels_seen++;
            if (req_row_end)
               rows_seen++;
         end
      end
   end

   // Output side: random stall bursts plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_asks != holds_done) begin
         holds_done <= holds_done + 1;
         hold_left  <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic send_pixel(input logic [7:0] px, input logic last);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel   <= px;
      req_row_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (encoded_stream.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] opaque_pixel();
      return 8'($urandom_range(0, 254));
   endfunction

   task automatic test_short_rows();
      send_pixel(8'h00, 1'b1);
      send_pixel(TRANSPARENT, 1'b1);
      send_pixel(8'hFE, 1'b1);
      send_pixel(TRANSPARENT, 1'b0);
      send_pixel(TRANSPARENT, 1'b0);
      send_pixel(8'h12, 1'b0);
      send_pixel(8'h34, 1'b0);
      send_pixel(TRANSPARENT, 1'b0);
      send_pixel(8'h56, 1'b1);
      send_pixel(8'h01, 1'b0);
      send_pixel(TRANSPARENT, 1'b0);
      send_pixel(TRANSPARENT, 1'b1);
      wait_drained();
   endtask

   // A transparent run longer than the counter can hold, then a row ending on
   // transparency after a near-full literal, which holds back its terminator.
   // The receiver stalls meanwhile so the input side backs up.
   task automatic test_held_terminator();
      hold_asks++;
      for (int i = 0; i < 64; i++)
         send_pixel(TRANSPARENT, 1'b0);
      for (int i = 0; i < MAX_WIDTH - 1; i++)
         send_pixel(opaque_pixel(), 1'b0);
      send_pixel(TRANSPARENT, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_rows(input int pixels_wanted);
      int sent;
      int width;
      int density;
      logic [7:0] px;
      sent = 0;
      while (sent < pixels_wanted) begin
         case ($urandom_range(0, 9))
            0: width = $urandom_range(11, 20);
            1: width = 1;
            default: width = $urandom_range(2, 10);
         endcase
         density = $urandom_range(0, 100);
         for (int i = 0; i < width; i++) begin
            if ($urandom_range(1, 100) <= density)
               px = TRANSPARENT;
            else
               px = opaque_pixel();
            send_pixel(px, i == width - 1);
         end
         sent += width;
      end
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_rows();
      test_held_terminator();
      test_random_rows(20);
      idling_on = 1'b0;
      test_random_rows(14);
      $display("Encoded %0d rows (%0d pixels) and checked %0d output bytes.",
               rows_seen, pixels_seen, bytes_seen);
      $display("Covered skip saturation, held-back terminator, long stalls, random rows.");
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
